>>> hw/rtl/tcaf_pkg.sv
// Shared types and constants for the triggered classify and actuate controller.
package tcaf_pkg;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int ELAPSED_W = 10;
  localparam int PROB_W    = 16;
  localparam int PULSE_W   = 12;
  localparam int TIMER_W   = 16;
  localparam int SUM_W     = 19;
  localparam int COUNT_W   = 3;
  localparam int PHASE_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [PHASE_W-1:0] PHASE_IDLE    = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_ARMED   = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_COLLECT = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_HOLD    = 2'd3;

  localparam logic [PULSE_W-1:0] OPEN_PULSE_RST   = 12'd1500;
  localparam logic [PULSE_W-1:0] CLOSED_PULSE_RST = 12'd1000;
  localparam logic [TIMER_W-1:0] EMPTY_DELAY_RST  = 16'd2000;
  localparam logic [PROB_W-1:0]  TGT_THRESH_RST   = 16'd45875;
  localparam logic [TIMER_W-1:0] TIMER_MAX        = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OPEN_PULSE   = 2'd0,
    CFG_CLOSED_PULSE = 2'd1,
    CFG_EMPTY_DELAY  = 2'd2,
    CFG_TGT_THRESH   = 2'd3
  } tcaf_cfg_idx_t;

  typedef struct packed {
    logic                 beam;
    logic                 clr;
    logic [ELAPSED_W-1:0] elapsed;
    logic                 valid;
    logic [PROB_W-1:0]    target;
  } tcaf_item_t;

endpackage

>>> hw/rtl/triggered_classify_actuate_fsm.sv
// Top level of the triggered classify and actuate controller.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_push / in_full    | beam, sim, elapsed, result and probabilities
//  out_    | output    | out_empty / out_pop  | beam_broken, servo_closed, pulse width, phase
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One poll per cycle while in_full is low; an accepted poll is written into the queue,
// then taken into the back end's update register, which drives the out_ ports.
// A two-entry queue sits between front and back; while a result waits unpopped,
// the queue still takes two more polls before in_full rises.
// Synchronous reset clears phase, sum, count, timer and queues, and restores
// the config registers to their defaults. cfg_ready is always high.
module triggered_classify_actuate_fsm #(
  parameter int RESULTS_NEEDED = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic                            in_beam_level,
  input  logic                            in_sim_beam,
  input  logic [tcaf_pkg::ELAPSED_W-1:0]  in_elapsed_ms,
  input  logic                            in_result_valid,
  input  logic [tcaf_pkg::PROB_W-1:0]     in_target_prob,
  input  logic [tcaf_pkg::PROB_W-1:0]     in_other_prob,
  input  logic [tcaf_pkg::PROB_W-1:0]     in_blank_prob,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic                            out_beam_broken,
  output logic                            out_servo_closed,
  output logic [tcaf_pkg::PULSE_W-1:0]    out_pulse_width_us,
  output logic [tcaf_pkg::PHASE_W-1:0]    out_phase,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tcaf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcaf_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import tcaf_pkg::*;

  logic       q_full;
  logic       q_wr;
  tcaf_item_t q_wr_item;
  logic       q_rd;
  logic       q_valid;
  tcaf_item_t q_rd_item;

  tcaf_front u_front (
    .in_push         (in_push),
    .in_full         (in_full),
    .in_beam_level   (in_beam_level),
    .in_sim_beam     (in_sim_beam),
    .in_elapsed_ms   (in_elapsed_ms),
    .in_result_valid (in_result_valid),
    .in_target_prob  (in_target_prob),
    .in_other_prob   (in_other_prob),
    .in_blank_prob   (in_blank_prob),
    .q_full          (q_full),
    .q_wr            (q_wr),
    .q_item          (q_wr_item)
  );

  tcaf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (q_wr),
    .wr_item  (q_wr_item),
    .full     (q_full),
    .rd       (q_rd),
    .rd_valid (q_valid),
    .rd_item  (q_rd_item)
  );

  tcaf_back #(
    .RESULTS_NEEDED (RESULTS_NEEDED)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_item             (q_rd_item),
    .q_rd               (q_rd),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_beam_broken    (out_beam_broken),
    .out_servo_closed   (out_servo_closed),
    .out_pulse_width_us (out_pulse_width_us),
    .out_phase          (out_phase)
  );

endmodule

>>> hw/rtl/tcaf_front.sv
// Front end: accepts polls and classifies beam and emptiness into a queue item.
module tcaf_front (
  input  logic                       in_push,
  output logic                       in_full,
  input  logic                       in_beam_level,
  input  logic                       in_sim_beam,
  input  logic [tcaf_pkg::ELAPSED_W-1:0] in_elapsed_ms,
  input  logic                       in_result_valid,
  input  logic [tcaf_pkg::PROB_W-1:0] in_target_prob,
  input  logic [tcaf_pkg::PROB_W-1:0] in_other_prob,
  input  logic [tcaf_pkg::PROB_W-1:0] in_blank_prob,
  input  logic                       q_full,
  output logic                       q_wr,
  output tcaf_pkg::tcaf_item_t       q_item
);
  import tcaf_pkg::*;

  logic beam;
  logic not_empty;

  assign beam      = !in_beam_level || in_sim_beam;
  assign not_empty = in_result_valid &&
                     ((in_blank_prob < in_target_prob) || (in_blank_prob < in_other_prob));

  assign in_full = q_full;
  assign q_wr    = in_push && !q_full;

  always_comb begin
    q_item.beam    = beam;
    q_item.clr     = beam || not_empty;
    q_item.elapsed = in_elapsed_ms;
    q_item.valid   = in_result_valid;
    q_item.target  = in_target_prob;
  end

endmodule

>>> hw/rtl/tcaf_queue.sv
// Short item queue between the front end and the back end.
module tcaf_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr,
  input  tcaf_pkg::tcaf_item_t wr_item,
  output logic                 full,
  input  logic                 rd,
  output logic                 rd_valid,
  output tcaf_pkg::tcaf_item_t rd_item
);
  import tcaf_pkg::*;

  tcaf_item_t        slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full     = (count_r == QCNT_W'(QDEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr && !rd) begin
        count_r <= count_r + 1'b1;
      end else if (rd && !wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/tcaf_back.sv
// Back end: phase machine, sum and timer, config registers and result register.
module tcaf_back #(
  parameter int RESULTS_NEEDED = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  tcaf_pkg::tcaf_item_t            q_item,
  output logic                            q_rd,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tcaf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcaf_pkg::CFG_DAT_W-1:0]  cfg_data,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic                            out_beam_broken,
  output logic                            out_servo_closed,
  output logic [tcaf_pkg::PULSE_W-1:0]    out_pulse_width_us,
  output logic [tcaf_pkg::PHASE_W-1:0]    out_phase
);
  import tcaf_pkg::*;

  typedef enum logic [PHASE_W-1:0] {
    ST_IDLE    = PHASE_IDLE,
    ST_ARMED   = PHASE_ARMED,
    ST_COLLECT = PHASE_COLLECT,
    ST_HOLD    = PHASE_HOLD
  } state_t;

  state_t               state_r, state_nxt;
  logic                 closed_r, closed_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [TIMER_W-1:0]   timer_r, timer_nxt;

  logic [PULSE_W-1:0]   open_pulse_r;
  logic [PULSE_W-1:0]   closed_pulse_r;
  logic [TIMER_W-1:0]   empty_delay_r;
  logic [PROB_W-1:0]    tgt_thresh_r;

  logic                 out_valid_r;
  logic                 beam_r;
  logic                 servo_r;
  logic [PULSE_W-1:0]   pulse_r;
  logic [PHASE_W-1:0]   phase_r;

  logic                 take;
  logic [SUM_W-1:0]     sum_add;
  logic [COUNT_W-1:0]   count_add;
  logic [SUM_W-1:0]     limit;
  logic [TIMER_W:0]     timer_add;
  logic [TIMER_W-1:0]   timer_upd;

  assign take      = q_valid && (!out_valid_r || out_pop);
  assign q_rd      = take;
  assign cfg_ready = 1'b1;

  assign sum_add   = q_item.valid ? sum_r + SUM_W'(q_item.target) : sum_r;
  assign count_add = q_item.valid ? count_r + 1'b1 : count_r;
  assign limit     = SUM_W'(tgt_thresh_r) * SUM_W'(RESULTS_NEEDED);
  assign timer_add = {1'b0, timer_r} + (TIMER_W + 1)'(q_item.elapsed);

  always_comb begin
    state_nxt  = state_r;
    closed_nxt = closed_r;
    sum_nxt    = sum_r;
    count_nxt  = count_r;
    timer_nxt  = timer_r;
    timer_upd  = '0;
    case (state_r)
      ST_IDLE: begin
        if (q_item.beam) begin
          state_nxt = ST_ARMED;
          sum_nxt   = '0;
          count_nxt = '0;
        end
      end
      ST_ARMED, ST_COLLECT: begin
        if (count_add >= COUNT_W'(RESULTS_NEEDED)) begin
          if (sum_add > limit) begin
            closed_nxt = 1'b1;
            timer_nxt  = '0;
            state_nxt  = ST_HOLD;
          end else begin
            state_nxt = ST_IDLE;
          end
          sum_nxt   = '0;
          count_nxt = '0;
        end else begin
          state_nxt = ST_COLLECT;
          sum_nxt   = sum_add;
          count_nxt = count_add;
        end
      end
      ST_HOLD: begin
        if (q_item.clr) begin
          timer_upd = '0;
        end else if (timer_add[TIMER_W]) begin
          timer_upd = TIMER_MAX;
        end else begin
          timer_upd = timer_add[TIMER_W-1:0];
        end
        timer_nxt = timer_upd;
        if (timer_upd >= empty_delay_r) begin
          closed_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      closed_r    <= 1'b0;
      sum_r       <= '0;
      count_r     <= '0;
      timer_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        state_r  <= state_nxt;
        closed_r <= closed_nxt;
        sum_r    <= sum_nxt;
        count_r  <= count_nxt;
        timer_r  <= timer_nxt;
        beam_r   <= q_item.beam;
        servo_r  <= closed_nxt;
        pulse_r  <= closed_nxt ? closed_pulse_r : open_pulse_r;
        phase_r  <= state_nxt;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_pulse_r   <= OPEN_PULSE_RST;
      closed_pulse_r <= CLOSED_PULSE_RST;
      empty_delay_r  <= EMPTY_DELAY_RST;
      tgt_thresh_r   <= TGT_THRESH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (tcaf_cfg_idx_t'(cfg_index))
        CFG_OPEN_PULSE:   open_pulse_r   <= cfg_data[PULSE_W-1:0];
        CFG_CLOSED_PULSE: closed_pulse_r <= cfg_data[PULSE_W-1:0];
        CFG_EMPTY_DELAY:  empty_delay_r  <= cfg_data[TIMER_W-1:0];
        CFG_TGT_THRESH:   tgt_thresh_r   <= cfg_data[PROB_W-1:0];
        default: begin
          tgt_thresh_r <= tgt_thresh_r;
        end
      endcase
    end
  end

  assign out_empty          = !out_valid_r;
  assign out_beam_broken    = beam_r;
  assign out_servo_closed   = servo_r;
  assign out_pulse_width_us = pulse_r;
  assign out_phase          = phase_r;

endmodule

>>> hw/rtl/tcaf_checker.sv
// Port-level checker for the controller and its bind to the top level.
module tcaf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_empty,
  input logic                           out_pop,
  input logic                           out_beam_broken,
  input logic                           out_servo_closed,
  input logic [tcaf_pkg::PULSE_W-1:0]   out_pulse_width_us,
  input logic [tcaf_pkg::PHASE_W-1:0]   out_phase
);
  import tcaf_pkg::*;

  a_reset_empty: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> out_empty)
    else $error("result present right after reset");

  a_closed_iff_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ((out_phase == PHASE_HOLD) == out_servo_closed))
    else $error("servo position disagrees with phase");

  a_armed_needs_beam: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_phase == PHASE_ARMED) |-> out_beam_broken)
    else $error("armed without a broken beam");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_phase) && $stable(out_pulse_width_us)))
    else $error("stalled item changed");

endmodule

bind triggered_classify_actuate_fsm tcaf_checker u_tcaf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_empty          (out_empty),
  .out_pop            (out_pop),
  .out_beam_broken    (out_beam_broken),
  .out_servo_closed   (out_servo_closed),
  .out_pulse_width_us (out_pulse_width_us),
  .out_phase          (out_phase)
);

>>> test/tb.sv
// Testbench for the controller: directed and random polls checked against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcaf_pkg::*;

  localparam int NEEDED = 5;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic                 beam_level;
    logic                 sim_beam;
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic                 result_valid;
    logic [PROB_W-1:0]    target_prob;
    logic [PROB_W-1:0]    other_prob;
    logic [PROB_W-1:0]    blank_prob;
  } poll_t;

  typedef struct {
    logic               beam_broken;
    logic               servo_closed;
    logic [PULSE_W-1:0] pulse_width_us;
    logic [PHASE_W-1:0] phase;
  } poll_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_push;
  logic in_full;
  logic in_beam_level;
  logic in_sim_beam;
  logic [ELAPSED_W-1:0] in_elapsed_ms;
  logic in_result_valid;
  logic [PROB_W-1:0] in_target_prob;
  logic [PROB_W-1:0] in_other_prob;
  logic [PROB_W-1:0] in_blank_prob;
  logic out_empty;
  logic out_pop;
  logic out_beam_broken;
  logic out_servo_closed;
  logic [PULSE_W-1:0] out_pulse_width_us;
  logic [PHASE_W-1:0] out_phase;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  triggered_classify_actuate_fsm #(.RESULTS_NEEDED(NEEDED)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_beam_level(in_beam_level), .in_sim_beam(in_sim_beam),
    .in_elapsed_ms(in_elapsed_ms), .in_result_valid(in_result_valid),
    .in_target_prob(in_target_prob), .in_other_prob(in_other_prob),
    .in_blank_prob(in_blank_prob),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_beam_broken(out_beam_broken), .out_servo_closed(out_servo_closed),
    .out_pulse_width_us(out_pulse_width_us), .out_phase(out_phase),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [PULSE_W-1:0] open_us;
  logic [PULSE_W-1:0] closed_us;
  logic [TIMER_W-1:0] delay_ms;
  logic [PROB_W-1:0]  tgt_thresh;

  logic [PHASE_W-1:0] ctl_phase;
  logic               ctl_closed;
  logic [SUM_W-1:0]   ctl_sum;
  logic [COUNT_W-1:0] ctl_count;
  logic [TIMER_W-1:0] ctl_timer;

  poll_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int pop_wait = 0;
  bit quiet = 1'b0;

  function automatic poll_result_t predict_poll(poll_t p);
    poll_result_t r;
    logic broken;
    logic [16:0] sum_t;
    logic [19:0] limit;
    broken = !p.beam_level || p.sim_beam;
    case (ctl_phase)
      PHASE_IDLE: begin
        if (broken) begin
          ctl_phase = PHASE_ARMED;
          ctl_sum = '0;
          ctl_count = '0;
        end
      end
      PHASE_ARMED, PHASE_COLLECT: begin
        ctl_phase = PHASE_COLLECT;
        if (p.result_valid) begin
          ctl_sum = ctl_sum + SUM_W'(p.target_prob);
          ctl_count = ctl_count + 1'b1;
        end
        if (ctl_count >= NEEDED) begin
          limit = 20'(tgt_thresh * NEEDED);
          if ({1'b0, ctl_sum} > limit) begin
            ctl_closed = 1'b1;
            ctl_timer = '0;
            ctl_phase = PHASE_HOLD;
          end else begin
            ctl_phase = PHASE_IDLE;
          end
          ctl_sum = '0;
          ctl_count = '0;
        end
      end
      default: begin
        if (broken || (p.result_valid && (p.blank_prob < p.target_prob ||
                                          p.blank_prob < p.other_prob))) begin
          ctl_timer = '0;
        end else begin
          sum_t = {1'b0, ctl_timer} + 17'(p.elapsed_ms);
          ctl_timer = (sum_t > 17'(TIMER_MAX)) ? TIMER_MAX : sum_t[TIMER_W-1:0];
        end
        if (ctl_timer >= delay_ms) begin
          ctl_closed = 1'b0;
          ctl_phase = PHASE_IDLE;
        end
      end
    endcase
    r.beam_broken = broken;
    r.servo_closed = ctl_closed;
    r.pulse_width_us = ctl_closed ? closed_us : open_us;
    r.phase = ctl_phase;
    return r;
  endfunction

  function automatic poll_t poll_of(int lvl, int sim, int elapsed, int valid,
                                    int tgt, int oth, int emp);
    poll_t p;
    p.beam_level = lvl[0];
    p.sim_beam = sim[0];
    p.elapsed_ms = ELAPSED_W'(elapsed);
    p.result_valid = valid[0];
    p.target_prob = PROB_W'(tgt);
    p.other_prob = PROB_W'(oth);
    p.blank_prob = PROB_W'(emp);
    return p;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    poll_result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, actual phase %0d", $time, out_phase);
      end else begin
        want = pending_results.pop_front();
        check_field("beam_broken", want.beam_broken, out_beam_broken);
        check_field("servo_closed", want.servo_closed, out_servo_closed);
        check_field("pulse_width_us", want.pulse_width_us, out_pulse_width_us);
        check_field("phase", want.phase, out_phase);
      end
      pop_wait = quiet ? 0 : $urandom_range(0, 13);
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop = 1'b0;
    end else if (pop_wait > 0) begin
      out_pop = 1'b0;
      pop_wait--;
    end else begin
      out_pop = 1'b1;
    end
  end

  task automatic send_poll(poll_t p);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      in_push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_beam_level = p.beam_level;
    in_sim_beam = p.sim_beam;
    in_elapsed_ms = p.elapsed_ms;
    in_result_valid = p.result_valid;
    in_target_prob = p.target_prob;
    in_other_prob = p.other_prob;
    in_blank_prob = p.blank_prob;
    in_push = 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    pending_results.insert(pending_results.size(), predict_poll(p));
  endtask

  task automatic settle();
    @(negedge clk);
    in_push = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(tcaf_cfg_idx_t idx, logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_OPEN_PULSE:   open_us = val[PULSE_W-1:0];
      CFG_CLOSED_PULSE: closed_us = val[PULSE_W-1:0];
      CFG_EMPTY_DELAY:  delay_ms = val;
      default:          tgt_thresh = val;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic collect_results(int tgt);
    repeat (NEEDED) send_poll(poll_of(1, 0, 0, 1, tgt, 0, 0));
  endtask

  function automatic poll_t shaped_poll();
    poll_t p;
    int t;
    p = poll_of($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1023),
                $urandom_range(0, 1), $urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535));
    if ($urandom_range(0, 9) == 0) return p;
    case (ctl_phase)
      PHASE_IDLE: begin
        if ($urandom_range(0, 9) < 6) begin
          p.sim_beam = p.beam_level ? 1'b1 : p.sim_beam;
        end else begin
          p.beam_level = 1'b1;
          p.sim_beam = 1'b0;
        end
      end
      PHASE_ARMED, PHASE_COLLECT: begin
        p.result_valid = ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 3) != 0) begin
          t = int'(tgt_thresh) + $urandom_range(0, 8000) - 4000;
          p.target_prob = PROB_W'((t < 0) ? 0 : (t > 65535) ? 65535 : t);
        end
      end
      default: begin
        p.beam_level = ($urandom_range(0, 19) != 0);
        p.sim_beam = ($urandom_range(0, 19) == 0);
        if (p.result_valid && $urandom_range(0, 4) != 0) begin
          p.blank_prob = PROB_W'($urandom_range(32768, 65535));
          p.target_prob = PROB_W'($urandom_range(0, p.blank_prob));
          p.other_prob = PROB_W'($urandom_range(0, p.blank_prob));
        end
      end
    endcase
    return p;
  endfunction

  task automatic test_idle_ignores();
    send_poll(poll_of(1, 0, 1023, 1, 65535, 0, 0));
    send_poll(poll_of(1, 0, 0, 0, 0, 65535, 65535));
  endtask

  task automatic test_trigger_and_hold();
    send_poll(poll_of(0, 0, 0, 1, 65535, 0, 0));
    send_poll(poll_of(0, 1, 12, 0, 65535, 0, 0));
    send_poll(poll_of(1, 1, 0, 1, 65535, 0, 0));
    repeat (NEEDED - 1) send_poll(poll_of(1, 0, 0, 1, 65535, 0, 0));
    send_poll(poll_of(1, 0, 1023, 1, 0, 0, 65535));
    send_poll(poll_of(1, 1, 500, 0, 0, 0, 0));
    send_poll(poll_of(1, 0, 1023, 0, 0, 0, 0));
    send_poll(poll_of(1, 0, 1023, 1, 200, 0, 100));
    send_poll(poll_of(1, 0, 1023, 1, 0, 300, 200));
    send_poll(poll_of(1, 0, 1023, 1, 400, 400, 400));
    send_poll(poll_of(1, 0, 1023, 0, 0, 0, 0));
    send_poll(poll_of(1, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_threshold_edge();
    send_poll(poll_of(1, 1, 0, 0, 0, 0, 0));
    collect_results(TGT_THRESH_RST);
    send_poll(poll_of(1, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_register_extremes();
    settle();
    write_reg(CFG_OPEN_PULSE, 16'd2500);
    write_reg(CFG_CLOSED_PULSE, 16'd500);
    write_reg(CFG_EMPTY_DELAY, 16'd0);
    write_reg(CFG_TGT_THRESH, 16'd0);
    send_poll(poll_of(0, 1, 0, 0, 0, 0, 0));
    repeat (NEEDED - 1) send_poll(poll_of(1, 0, 0, 1, 0, 0, 0));
    send_poll(poll_of(1, 0, 0, 1, 1, 0, 0));
    send_poll(poll_of(0, 0, 0, 0, 0, 0, 0));
    send_poll(poll_of(1, 0, 0, 0, 0, 0, 0));
    settle();
    write_reg(CFG_TGT_THRESH, 16'hFFFF);
    send_poll(poll_of(0, 0, 0, 0, 0, 0, 0));
    collect_results(65535);
    settle();
    write_reg(CFG_OPEN_PULSE, 16'd500);
    write_reg(CFG_CLOSED_PULSE, 16'hF9C4);
    write_reg(CFG_EMPTY_DELAY, 16'hFFFF);
    write_reg(CFG_TGT_THRESH, 16'd0);
    send_poll(poll_of(0, 0, 0, 0, 0, 0, 0));
    collect_results(1);
    repeat (66) send_poll(poll_of(1, 0, 1023, 0, 0, 0, 0));
  endtask

  task automatic test_random_sequences();
    for (int phase_no = 0; phase_no < 8; phase_no++) begin
      settle();
      write_reg(CFG_OPEN_PULSE, CFG_DAT_W'($urandom_range(500, 2500)));
      write_reg(CFG_CLOSED_PULSE, CFG_DAT_W'($urandom_range(500, 2500)));
      write_reg(CFG_EMPTY_DELAY, (phase_no == 0) ? 16'd0 : (phase_no == 1) ? 16'hFFFF :
                                 16'($urandom_range(0, 4000)));
      write_reg(CFG_TGT_THRESH, (phase_no == 2) ? 16'd0 : (phase_no == 3) ? 16'hFFFF :
                                16'($urandom_range(0, 65535)));
      quiet = (phase_no % 3 == 2);
      repeat (175) send_poll(shaped_poll());
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_beam_level = 1'b1;
    in_sim_beam = 1'b0;
    in_elapsed_ms = '0;
    in_result_valid = 1'b0;
    in_target_prob = '0;
    in_other_prob = '0;
    in_blank_prob = '0;
    out_pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_OPEN_PULSE;
    cfg_data = '0;
    open_us = OPEN_PULSE_RST;
    closed_us = CLOSED_PULSE_RST;
    delay_ms = EMPTY_DELAY_RST;
    tgt_thresh = TGT_THRESH_RST;
    ctl_phase = PHASE_IDLE;
    ctl_closed = 1'b0;
    ctl_sum = '0;
    ctl_count = '0;
    ctl_timer = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_idle_ignores();
    test_trigger_and_hold();
    test_threshold_edge();
    test_register_extremes();
    test_random_sequences();
    settle();
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
